/* design/rgb_kernel_convolution_core_defines.svh */
// Assertion macros used by the convolution core controller.
`ifndef RGB_KERNEL_CONVOLUTION_CORE_DEFINES_SVH
`define RGB_KERNEL_CONVOLUTION_CORE_DEFINES_SVH

// Property checked on every clock edge out of reset.
`define RKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RKC_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) else $error(msg);

`endif

/* design/rkc_pkg.sv */
// Shared types and constants of the RGB kernel convolution core.
package rkc_pkg;

  localparam int unsigned CH_N       = 3;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_N      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned IMG_W_W    = 12;
  localparam int unsigned IMG_H_W    = 16;

  localparam int PIX_BIAS = 128;
  localparam int PIX_MAX  = 255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ROW0   = 3'd2,
    CFG_ROW1   = 3'd3,
    CFG_ROW2   = 3'd4,
    CFG_ROW3   = 3'd5,
    CFG_ROW4   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic start_emit;
    logic rd_border;
    logic tap_issue;
    logic div_init;
    logic div_step;
    logic load_out;
  } rkc_cmd_t;

  typedef struct packed {
    logic drain;
    logic frame_done;
    logic emit_ok;
    logic border;
    logic last_tap;
    logic tot_zero;
    logic div_done;
  } rkc_sts_t;

endpackage

/* design/rkc_ctrl.sv */
// Sequencer of the convolution core: handshakes and per-pixel step order.
`include "rgb_kernel_convolution_core_defines.svh"

module rkc_ctrl import rkc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rkc_sts_t sts_i,
  output rkc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EMIT, ST_TAPS, ST_TLAST, ST_DINIT, ST_DIV, ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.drain) begin
            state_d = sts_i.frame_done ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = sts_i.emit_ok ? ST_EMIT : ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.start_emit = 1'b1;
        if (sts_i.border) begin
          cmd_o.rd_border = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_TAPS;
        end
      end
      ST_TAPS: begin
        cmd_o.tap_issue = 1'b1;
        if (sts_i.last_tap) state_d = ST_TLAST;
      end
      ST_TLAST: state_d = ST_DINIT;
      ST_DINIT: begin
        if (sts_i.tot_zero) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `RKC_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  `RKC_ASSERT_NEXT(a_idle_drain, cmd_o.accept && sts_i.drain && !sts_i.frame_done, state_q == ST_IDLE, "idle drain emitted")
  `RKC_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> !sts_i.tot_zero, "divide by zero total")
  `RKC_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result outside finish")

endmodule

/* design/rkc_dp.sv */
// Datapath: config registers, line store, window MAC and bit-serial divider.
module rkc_dp import rkc_pkg::*; #(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  op_i,
  input  logic [PIX_W-1:0]      in_red_i,
  input  logic [PIX_W-1:0]      in_green_i,
  input  logic [PIX_W-1:0]      in_blue_i,
  input  rkc_cmd_t              cmd_i,
  output rkc_sts_t              sts_o,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic                  frame_end_o
);

  localparam int Off    = (KSIZE - 1) / 2;
  localparam int Far    = KSIZE - 1 - Off;
  localparam int KIW    = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int Depth  = KSIZE * MAX_WIDTH;
  localparam int ADW    = $clog2(Depth);
  localparam int LRaw   = $clog2(Far * MAX_WIDTH + Far + 1);
  localparam int LW     = (LRaw > 0) ? LRaw : 1;
  localparam int AW     = $clog2(KSIZE * KSIZE * 128 * 255 + 1) + 1;
  localparam int MW     = AW - 1;
  localparam int TW     = $clog2(KSIZE * KSIZE * 128 + 1) + 1;
  localparam int DM     = TW - 1;
  localparam int DCW    = $clog2(MW);
  localparam int SSW    = $clog2(3 * KSIZE + 1);
  localparam int PW     = PIX_W * CH_N;

  // config
  logic [IMG_W_W-1:0]    img_w_q;
  logic [IMG_H_W-1:0]    img_h_q;
  logic [CFG_DATA_W-1:0] coef_q [ROW_N];
  logic                  restart;

  assign restart = cfg_we_i && ((cfg_index_i == CFG_WIDTH) || (cfg_index_i == CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_W_W'(640);
      img_h_q <= IMG_H_W'(480);
      for (int i = 0; i < ROW_N; i++) coef_q[i] <= '0;
      coef_q[1] <= CFG_DATA_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  img_w_q   <= cfg_wdata_i[IMG_W_W-1:0];
        CFG_HEIGHT: img_h_q   <= cfg_wdata_i[IMG_H_W-1:0];
        CFG_ROW0:   coef_q[0] <= cfg_wdata_i;
        CFG_ROW1:   coef_q[1] <= cfg_wdata_i;
        CFG_ROW2:   coef_q[2] <= cfg_wdata_i;
        CFG_ROW3:   coef_q[3] <= cfg_wdata_i;
        CFG_ROW4:   coef_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [13:0]        w_ext;
  logic [WW-1:0]      w;
  logic [IMG_H_W-1:0] h;

  always_comb begin
    if (img_w_q == '0) begin
      w_ext = 14'd1;
    end else if ({2'b0, img_w_q} > 14'(MAX_WIDTH)) begin
      w_ext = 14'(MAX_WIDTH);
    end else begin
      w_ext = {2'b0, img_w_q};
    end
  end
  assign w = w_ext[WW-1:0];
  assign h = (img_h_q == '0) ? IMG_H_W'(1) : img_h_q;

  // position counters
  logic [CW-1:0]      in_col_q, out_col_q;
  logic [IMG_H_W-1:0] in_row_q, out_row_q;
  logic [KIW-1:0]     in_slot_q, out_slot_q;
  logic [LW-1:0]      seen_q, lag;
  logic               done_q;
  logic               pix_acc, in_col_end, in_row_end, frame_wrap;
  logic               out_col_end, last, border;

  assign pix_acc     = cmd_i.accept && (op_i == OP_PIXEL);
  assign in_col_end  = (WW'(in_col_q) + WW'(1)) >= w;
  assign in_row_end  = (in_row_q + IMG_H_W'(1)) >= h;
  assign frame_wrap  = in_col_end && in_row_end;
  assign lag         = LW'(Far) * LW'(w) + LW'(Far);
  assign out_col_end = (WW'(out_col_q) + WW'(1)) >= w;
  assign last        = (out_row_q == (h - IMG_H_W'(1))) && out_col_end;
  assign border      = (out_row_q < IMG_H_W'(Off)) || (out_col_q < CW'(Off)) ||
                       (({1'b0, out_row_q} + (IMG_H_W+1)'(Far)) >= {1'b0, h}) ||
                       (((WW+1)'(out_col_q) + (WW+1)'(Far)) >= (WW+1)'(w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      seen_q     <= '0;
      done_q     <= 1'b0;
    end else if (restart) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      seen_q     <= '0;
      done_q     <= 1'b0;
    end else if (pix_acc) begin
      if (done_q) begin
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
      end
      done_q <= frame_wrap;
      if (frame_wrap) begin
        seen_q <= '0;
      end else if (seen_q < lag) begin
        seen_q <= seen_q + LW'(1);
      end
      if (in_col_end) begin
        in_col_q <= '0;
        if (in_row_end) begin
          in_row_q  <= '0;
          in_slot_q <= '0;
        end else begin
          in_row_q  <= in_row_q + IMG_H_W'(1);
          in_slot_q <= (in_slot_q == KIW'(KSIZE - 1)) ? '0 : in_slot_q + KIW'(1);
        end
      end else begin
        in_col_q <= in_col_q + CW'(1);
      end
    end else if (cmd_i.load_out) begin
      if (last) begin
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        done_q     <= 1'b0;
      end else if (out_col_end) begin
        out_col_q  <= '0;
        out_row_q  <= out_row_q + IMG_H_W'(1);
        out_slot_q <= (out_slot_q == KIW'(KSIZE - 1)) ? '0 : out_slot_q + KIW'(1);
      end else begin
        out_col_q <= out_col_q + CW'(1);
      end
    end
  end

  // tap walk over the window
  logic [KIW-1:0] m_q, n_q;
  logic [SSW-1:0] s_sum;
  logic [KIW-1:0] tap_slot;
  logic [CW-1:0]  tap_col;
  logic           last_tap;

  assign last_tap = (m_q == KIW'(KSIZE - 1)) && (n_q == KIW'(KSIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
      n_q <= '0;
    end else if (cmd_i.start_emit) begin
      m_q <= '0;
      n_q <= '0;
    end else if (cmd_i.tap_issue) begin
      if (n_q == KIW'(KSIZE - 1)) begin
        n_q <= '0;
        m_q <= m_q + KIW'(1);
      end else begin
        n_q <= n_q + KIW'(1);
      end
    end
  end

  always_comb begin
    s_sum = SSW'(out_slot_q) + SSW'(KSIZE - Off) + SSW'(m_q);
    if (s_sum >= SSW'(2 * KSIZE)) begin
      s_sum = s_sum - SSW'(2 * KSIZE);
    end else if (s_sum >= SSW'(KSIZE)) begin
      s_sum = s_sum - SSW'(KSIZE);
    end
    tap_slot = s_sum[KIW-1:0];
  end
  assign tap_col = out_col_q - CW'(Off) + CW'(n_q);

  // line store
  logic [PW-1:0]  mem_q [Depth];
  logic [PW-1:0]  rdata_q;
  logic [ADW-1:0] wr_addr, rd_addr;
  logic           rd_en;

  assign wr_addr = ADW'(in_slot_q) * ADW'(MAX_WIDTH) + ADW'(in_col_q);
  assign rd_addr = cmd_i.rd_border ? (ADW'(out_slot_q) * ADW'(MAX_WIDTH) + ADW'(out_col_q))
                                   : (ADW'(tap_slot) * ADW'(MAX_WIDTH) + ADW'(tap_col));
  assign rd_en   = cmd_i.rd_border || cmd_i.tap_issue;

  always_ff @(posedge clk_i) begin
    if (pix_acc) mem_q[wr_addr] <= {in_blue_i, in_green_i, in_red_i};
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // flipped kernel coefficient for the tap being read
  logic [2:0]         ri, ci;
  logic signed [7:0]  kd_q;
  logic               tap_vld_q;

  assign ri = 3'(KSIZE - 1) - 3'(m_q);
  assign ci = 3'(KSIZE - 1) - 3'(n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_issue) kd_q <= coef_q[ri][8*ci +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tap_vld_q <= 1'b0;
    else         tap_vld_q <= cmd_i.tap_issue;
  end

  // MAC and divider lanes
  logic signed [AW-1:0] acc_q [CH_N];
  logic signed [TW-1:0] ksum_q;
  logic signed [16:0]   prod [CH_N];
  logic [MW-1:0]        dvd_q [CH_N];
  logic [DM-1:0]        rem_q [CH_N];
  logic [DM-1:0]        dsr_q;
  logic [CH_N-1:0]      neg_q;
  logic [DCW-1:0]       dcnt_q;
  logic [AW-1:0]        a_abs [CH_N];
  logic [TW-1:0]        t_abs;
  logic [DM:0]          shifted [CH_N];
  logic [CH_N-1:0]      ge;

  always_comb begin
    t_abs = ksum_q[TW-1] ? -ksum_q : ksum_q;
    for (int c = 0; c < CH_N; c++) begin
      prod[c]    = kd_q * $signed({1'b0, rdata_q[8*c +: 8]});
      a_abs[c]   = acc_q[c][AW-1] ? -acc_q[c] : acc_q[c];
      shifted[c] = {rem_q[c], dvd_q[c][MW-1]};
      ge[c]      = shifted[c] >= {1'b0, dsr_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      for (int c = 0; c < CH_N; c++) acc_q[c] <= '0;
      ksum_q <= '0;
    end else if (tap_vld_q) begin
      for (int c = 0; c < CH_N; c++) acc_q[c] <= acc_q[c] + AW'(prod[c]);
      ksum_q <= ksum_q + TW'(kd_q);
    end
    if (cmd_i.div_init) begin
      dsr_q  <= t_abs[DM-1:0];
      dcnt_q <= '0;
      for (int c = 0; c < CH_N; c++) begin
        dvd_q[c] <= a_abs[c][MW-1:0];
        rem_q[c] <= '0;
        neg_q[c] <= acc_q[c][AW-1] ^ ksum_q[TW-1];
      end
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCW'(1);
      for (int c = 0; c < CH_N; c++) begin
        rem_q[c] <= ge[c] ? DM'(shifted[c] - {1'b0, dsr_q}) : shifted[c][DM-1:0];
        dvd_q[c] <= {dvd_q[c][MW-2:0], ge[c]};
      end
    end
  end

  // result forming and output register
  logic [PIX_W-1:0]     res [CH_N];
  logic signed [AW:0]   biased [CH_N];
  logic [PIX_W-1:0]     out_q [CH_N];
  logic                 frame_end_q;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      biased[c] = (AW+1)'(acc_q[c]) - $signed((AW+1)'(PIX_BIAS));
      if (border) begin
        res[c] = rdata_q[8*c +: 8];
      end else if (ksum_q == '0) begin
        if (biased[c] < 0) begin
          res[c] = '0;
        end else if (biased[c] > $signed((AW+1)'(PIX_MAX))) begin
          res[c] = PIX_W'(PIX_MAX);
        end else begin
          res[c] = biased[c][PIX_W-1:0];
        end
      end else if (neg_q[c] && (dvd_q[c] != '0)) begin
        res[c] = '0;
      end else if (dvd_q[c] > MW'(PIX_MAX)) begin
        res[c] = PIX_W'(PIX_MAX);
      end else begin
        res[c] = dvd_q[c][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int c = 0; c < CH_N; c++) out_q[c] <= res[c];
      frame_end_q <= last;
    end
  end

  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign frame_end_o = frame_end_q;

  assign sts_o.drain      = (op_i == OP_DRAIN);
  assign sts_o.frame_done = done_q;
  assign sts_o.emit_ok    = seen_q >= lag;
  assign sts_o.border     = border;
  assign sts_o.last_tap   = last_tap;
  assign sts_o.tot_zero   = (ksum_q == '0);
  assign sts_o.div_done   = (dcnt_q == DCW'(MW - 1));

endmodule

/* design/rgb_kernel_convolution_core.sv */
// RGB square-kernel convolution core: top level.
// Takes RGB pixels in raster order and outputs each one convolved, per channel, with a signed
// KSIZE x KSIZE kernel (flipped in both axes), divided by the kernel coefficient sum with
// truncation toward zero (or with 128 subtracted when that sum is zero) and clamped to 0..255.
// Pixels whose window leaves the image pass through unchanged. Output pixel number p-L leaves
// after input pixel p, with L = FAR*width + FAR; once a frame is complete, each drain
// transaction (op = 1) releases one pending output, and frame_end marks the last output of a
// frame. Transactions run one at a time. A border pixel skips the window walk and the
// divide; an interior pixel's time is set by the single read port of the line store (one
// window tap per cycle) and by the one-bit-per-cycle divider, which is skipped when the
// kernel sum is zero. A finished result waits in the output register while the next input
// transaction is taken. Writing the width or height register restarts the frame; kernel
// rows take effect at once. Configuration must be written only while the core is idle;
// the core itself does not enforce this.
module rgb_kernel_convolution_core import rkc_pkg::*; #(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input transactions
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [PIX_W-1:0]      in_red_i,
  input  logic [PIX_W-1:0]      in_green_i,
  input  logic [PIX_W-1:0]      in_blue_i,
  // output transactions
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic                  frame_end_o
);

  rkc_cmd_t cmd;
  rkc_sts_t sts;

  // Step order: accept, border read or window walk and optional divide, then result load.
  rkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line store of KSIZE rows, window MAC, divider lanes and output register.
  rkc_dp #(
    .KSIZE    (KSIZE),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_i       (op_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .frame_end_o(frame_end_o)
  );

endmodule
